### hw/rtl/toy_cpu_execute_unit_core_macros.svh
// assertion macros for the execute unit
`ifndef TOY_CPU_EXECUTE_UNIT_CORE_MACROS_SVH
`define TOY_CPU_EXECUTE_UNIT_CORE_MACROS_SVH
`define TCX_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define TCX_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`endif

### hw/rtl/tcx_pkg.sv
// ----------------------------------------------------------------------------
// tcx_pkg
// shared types and codes of the execute unit
// ----------------------------------------------------------------------------
`default_nettype none
package tcx_pkg;
  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_AND = 5'd2, OP_XOR = 5'd3, OP_OR = 5'd4,
    OP_ADDI = 5'd5, OP_SUBI = 5'd6, OP_ANDI = 5'd7, OP_XORI = 5'd8, OP_ORI = 5'd9,
    OP_MOVI = 5'd10, OP_MOVR = 5'd11, OP_SWP = 5'd12, OP_MULL = 5'd13,
    OP_DIV = 5'd14, OP_PUSH = 5'd15, OP_POP = 5'd16, OP_SKIE = 5'd17
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_WB, ST_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic read;      // register operands
    logic exec;      // non-divide ops
    logic div_start;
    logic div_step;
    logic div_fin;
    logic wb2;       // second write / read back
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_div;
    logic div_done;
  } sts_t;

  localparam int unsigned IN_W = 5;
  localparam int unsigned OUT_W = 32;
endpackage
`default_nettype wire

### hw/rtl/tcx_stream_if.sv
// ----------------------------------------------------------------------------
// tcx_stream_if
// valid/ready channel carrying input or result beats
// ----------------------------------------------------------------------------
`default_nettype none
interface tcx_in_if;
  logic        valid;
  logic        ready;
  logic [4:0]  mode;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic signed [31:0] immediate;
  modport source (output valid, mode, dest_reg, src_reg_a, src_reg_b, immediate,
                  input ready);
  modport sink (input valid, mode, dest_reg, src_reg_a, src_reg_b, immediate,
                output ready);
endinterface

interface tcx_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] first_value;
  logic signed [31:0] second_value;
  logic        flag_parity;
  logic        flag_zero;
  logic        flag_sign;
  logic        flag_overflow;
  logic        skip_next;
  logic        divide_by_zero;
  modport source (output valid, first_value, second_value, flag_parity, flag_zero,
                  flag_sign, flag_overflow, skip_next, divide_by_zero, input ready);
  modport sink (input valid, first_value, second_value, flag_parity, flag_zero,
                flag_sign, flag_overflow, skip_next, divide_by_zero, output ready);
endinterface
`default_nettype wire

### hw/rtl/toy_cpu_execute_unit_core.sv
// steps: load, read, exec, write back, out; divide adds a loop of one quotient bit a cycle
// throughput: one instruction at a time; a new beat is taken once the result is registered
// the divider loop of DATA_WIDTH steps sets the worst case
// reset: asynchronous active low, clears registers, stack pointer, fill count and flags
// ----------------------------------------------------------------------------
// toy_cpu_execute_unit_core
// execute stage of a small register machine
// ----------------------------------------------------------------------------
`default_nettype none
module toy_cpu_execute_unit_core #(
  parameter int unsigned REG_COUNT   = 32,
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  tcx_in_if.sink    in_if,
  tcx_out_if.source out_if
);
  tcx_pkg::cmd_t cmd;
  tcx_pkg::sts_t sts;
  logic [3:0]    flags;
  logic [31:0]   fv, sv;
  logic          skip, dz;

  // sequencer
  tcx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // state and arithmetic
  tcx_dpath #(
    .REG_COUNT  (REG_COUNT),
    .STACK_DEPTH(STACK_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .mode_i         (in_if.mode),
    .dest_reg_i     (in_if.dest_reg),
    .src_reg_a_i    (in_if.src_reg_a),
    .src_reg_b_i    (in_if.src_reg_b),
    .immediate_i    (in_if.immediate),
    .first_value_o  (fv),
    .second_value_o (sv),
    .flags_o        (flags),
    .skip_next_o    (skip),
    .divide_by_zero_o(dz)
  );

  // result beat fields
  assign out_if.first_value    = fv;
  assign out_if.second_value   = sv;
  assign out_if.flag_parity    = flags[0];
  assign out_if.flag_zero      = flags[1];
  assign out_if.flag_sign      = flags[2];
  assign out_if.flag_overflow  = flags[3];
  assign out_if.skip_next      = skip;
  assign out_if.divide_by_zero = dz;
endmodule
`default_nettype wire

### hw/rtl/tcx_ctrl.sv
// ----------------------------------------------------------------------------
// tcx_ctrl
// sequencer for one instruction at a time
// ----------------------------------------------------------------------------
`default_nettype none
`include "toy_cpu_execute_unit_core_macros.svh"
module tcx_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  input  tcx_pkg::sts_t    sts_i,
  output tcx_pkg::cmd_t    cmd_o
);
  tcx_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcx_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = (state_q == tcx_pkg::ST_IDLE);
    unique case (state_q)
      tcx_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tcx_pkg::ST_READ;
        end
      end
      tcx_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = tcx_pkg::ST_EXEC;
      end
      tcx_pkg::ST_EXEC: begin
        if (sts_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = tcx_pkg::ST_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          state_d    = tcx_pkg::ST_WB;
        end
      end
      tcx_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.div_fin = 1'b1;
          state_d       = tcx_pkg::ST_WB;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      tcx_pkg::ST_WB: begin
        cmd_o.wb2 = 1'b1;
        state_d   = tcx_pkg::ST_OUT;
      end
      tcx_pkg::ST_OUT: begin
        // wait for the result register to drain
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = tcx_pkg::ST_IDLE;
        end
      end
      default: state_d = tcx_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  `TCX_ASSERT(a_load_idle, clk_i, rst_ni, !cmd_o.load || state_q == tcx_pkg::ST_IDLE, "load outside idle")
  `TCX_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q, "result dropped")
  `TCX_ASSERT_NEXT(a_load_read, clk_i, rst_ni, cmd_o.load, state_q == tcx_pkg::ST_READ, "no read after load")
endmodule
`default_nettype wire

### hw/rtl/tcx_dpath.sv
// ----------------------------------------------------------------------------
// tcx_dpath
// register file, stack memory, alu, multiplier and radix-2 divider
// ----------------------------------------------------------------------------
`default_nettype none
`include "toy_cpu_execute_unit_core_macros.svh"
module tcx_dpath #(
  parameter int unsigned REG_COUNT   = 32,
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  tcx_pkg::cmd_t    cmd_i,
  output tcx_pkg::sts_t    sts_o,
  input  wire logic [4:0]  mode_i,
  input  wire logic [4:0]  dest_reg_i,
  input  wire logic [4:0]  src_reg_a_i,
  input  wire logic [4:0]  src_reg_b_i,
  input  wire logic [31:0] immediate_i,
  output logic [31:0]      first_value_o,
  output logic [31:0]      second_value_o,
  output logic [3:0]       flags_o,
  output logic             skip_next_o,
  output logic             divide_by_zero_o
);
  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(W + 1);
  localparam int unsigned PW = SW + 1;

  // ---------------- instruction capture
  logic [4:0]    mode_q;
  logic [RW-1:0] ia_q, ib_q, ic_q;
  logic [W-1:0]  imm_q;
  logic [W-1:0] rf_q [REG_COUNT];
  logic [W-1:0] x_q, y_q, z_q;
  logic [3:0]   flags_q;
  logic         skip_q, dz_q;

  // index wrap as a small constant table
  function automatic logic [RW-1:0] ridx(input logic [4:0] r);
    logic [RW-1:0] t;
    t = '0;
    for (int k = 0; k < 32; k++) begin
      if (r == 5'(k)) t = RW'(k % REG_COUNT);
    end
    return t;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      ia_q   <= ridx(dest_reg_i);
      ib_q   <= ridx(src_reg_a_i);
      ic_q   <= ridx(src_reg_b_i);
      imm_q  <= W'(signed'(immediate_i));
    end
    if (cmd_i.read) begin
      x_q <= rf_q[ia_q];
      y_q <= rf_q[ib_q];
      z_q <= rf_q[ic_q];
    end
  end

  // ---------------- stack: memory with a rolling top pointer and fill count
  logic [W-1:0]  stk_mem [STACK_DEPTH];
  logic [SW-1:0] top_q;
  logic [PW-1:0] fill_q;
  logic [W-1:0]  stk_rd_q;

  // ---------------- alu and multiplier
  logic [W-1:0] opb, alu_r;
  logic         alu_ov;
  logic [2*W-1:0] prod;
  logic [W-1:0] mag_x, mag_y;
  logic         neg_xy;
  logic [2*W-1:0] mprod;
  logic         m_ov;

  function automatic logic [3:0] rflags(input logic [W-1:0] v, input logic ov);
    logic [3:0] f;
    f[0] = (^v) && !v[W-1] && (v != '0);
    f[1] = (v == '0);
    f[2] = v[W-1];
    f[3] = ov;
    return f;
  endfunction

  always_comb begin
    opb    = (mode_q <= 5'(tcx_pkg::OP_OR)) ? z_q : imm_q;
    alu_ov = 1'b0;
    unique case (mode_q)
      tcx_pkg::OP_ADD, tcx_pkg::OP_ADDI: begin
        alu_r  = y_q + opb;
        alu_ov = (y_q[W-1] == opb[W-1]) && (alu_r[W-1] != y_q[W-1]);
      end
      tcx_pkg::OP_SUB, tcx_pkg::OP_SUBI: begin
        alu_r  = y_q - opb;
        alu_ov = (y_q[W-1] != opb[W-1]) && (alu_r[W-1] != y_q[W-1]);
      end
      tcx_pkg::OP_AND, tcx_pkg::OP_ANDI: alu_r = y_q & opb;
      tcx_pkg::OP_XOR, tcx_pkg::OP_XORI: alu_r = y_q ^ opb;
      default: alu_r = y_q | opb;
    endcase
  end

  // multiply: operands x (dest reg) and y (source reg a) held in x_q/y_q after the index wrap above
  always_comb begin
    mag_x  = x_q[W-1] ? (~x_q + 1'b1) : x_q;
    mag_y  = y_q[W-1] ? (~y_q + 1'b1) : y_q;
    neg_xy = x_q[W-1] ^ y_q[W-1];
    mprod  = mag_x * mag_y;
    prod   = neg_xy ? (~mprod + 1'b1) : mprod;
    m_ov   = neg_xy ? (mprod > (2*W)'({1'b1, {(W-1){1'b0}}}))
                    : (mprod > (2*W)'({1'b0, {(W-1){1'b1}}}));
  end

  // ---------------- restoring divider, one bit a cycle
  logic [W-1:0]  dq_q, dr_q, dd_q;
  logic [CW-1:0] dcnt_q;
  logic [W:0]    dtrial;
  assign dtrial = {dr_q, dq_q[W-1]} - {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= CW'(W);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dq_q <= mag_x;
      dd_q <= mag_y;
      dr_q <= '0;
    end else if (cmd_i.div_step) begin
      if (!dtrial[W]) begin
        dr_q <= dtrial[W-1:0];
        dq_q <= {dq_q[W-2:0], 1'b1};
      end else begin
        dr_q <= {dr_q[W-2:0], dq_q[W-1]};
        dq_q <= {dq_q[W-2:0], 1'b0};
      end
    end
  end

  assign sts_o.is_div   = (mode_q == 5'(tcx_pkg::OP_DIV)) && (y_q != '0);
  assign sts_o.div_done = (dcnt_q == '0);

  // ---------------- write back
  // exec and div_fin: first write (port a) ; wb2: second write
  logic          w1_en, w2_en;
  logic [RW-1:0] w1_idx, w2_idx;
  logic [W-1:0]  w1_val, w2_val;
  logic [W-1:0]  sec_q;
  logic [W-1:0]  divq, divr;
  logic          push_q, pop_q;
  logic [W-1:0]  pop_val;

  assign divq = neg_xy ? (~dq_q + 1'b1) : dq_q;
  assign divr = x_q[W-1] ? (~dr_q + 1'b1) : dr_q;

  always_comb begin
    w1_en = 1'b0; w1_idx = ia_q; w1_val = alu_r;
    w2_en = 1'b0; w2_idx = ia_q; w2_val = sec_q;
    if (cmd_i.exec) begin
      unique case (mode_q)
        tcx_pkg::OP_ADD, tcx_pkg::OP_SUB, tcx_pkg::OP_AND, tcx_pkg::OP_XOR,
        tcx_pkg::OP_OR, tcx_pkg::OP_ADDI, tcx_pkg::OP_SUBI, tcx_pkg::OP_ANDI,
        tcx_pkg::OP_XORI, tcx_pkg::OP_ORI: w1_en = 1'b1;
        tcx_pkg::OP_MOVI: begin w1_en = 1'b1; w1_val = imm_q; end
        tcx_pkg::OP_MOVR: begin w1_en = 1'b1; w1_val = y_q; end
        tcx_pkg::OP_SWP: begin w1_en = 1'b1; w1_idx = ib_q; w1_val = x_q; end
        tcx_pkg::OP_MULL: begin
          w1_en = 1'b1; w1_idx = ib_q; w1_val = {{(W-4){1'b0}}, prod[3:0]};
        end
        default: w1_en = 1'b0;
      endcase
    end
    if (cmd_i.div_fin) begin
      w1_en = 1'b1; w1_idx = ia_q; w1_val = divq;
    end
    if (cmd_i.wb2) begin
      unique case (mode_q)
        tcx_pkg::OP_SWP, tcx_pkg::OP_MULL: w2_en = 1'b1;
        tcx_pkg::OP_DIV: begin w2_en = !dz_q; w2_idx = ib_q; end
        tcx_pkg::OP_POP: begin w2_en = 1'b1; w2_val = pop_val; end
        default: w2_en = 1'b0;
      endcase
    end
  end

  // second-write value and flag update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmd_i.exec) begin
      if (mode_q <= 5'(tcx_pkg::OP_ORI)) begin
        flags_q <= rflags(alu_r, (mode_q == 5'(tcx_pkg::OP_ADD) ||
                                  mode_q == 5'(tcx_pkg::OP_SUB) ||
                                  mode_q == 5'(tcx_pkg::OP_ADDI) ||
                                  mode_q == 5'(tcx_pkg::OP_SUBI)) ? alu_ov : flags_q[3]);
      end else if (mode_q == 5'(tcx_pkg::OP_MULL)) begin
        flags_q <= rflags(prod[W-1:0], m_ov);
      end
    end else if (cmd_i.div_fin) begin
      // flags follow the final first register, the remainder when both are one
      flags_q <= rflags((ia_q == ib_q) ? divr : divq, flags_q[3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      skip_q <= (mode_q == 5'(tcx_pkg::OP_SKIE)) && (x_q == y_q);
      dz_q   <= (mode_q == 5'(tcx_pkg::OP_DIV)) && (y_q == '0);
      if (mode_q == 5'(tcx_pkg::OP_SWP)) sec_q <= y_q;
      else sec_q <= {{4{prod[W-1]}}, prod[W-1:4]};
    end else if (cmd_i.div_fin) begin
      dz_q   <= 1'b0;
      skip_q <= 1'b0;
      sec_q  <= divr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) rf_q[i] <= '0;
    end else begin
      if (w1_en) rf_q[w1_idx] <= w1_val;
      if (w2_en) rf_q[w2_idx] <= w2_val;
    end
  end

  // stack: top at top_q, entries beyond fill read as zero
  logic [SW-1:0] top_m1;
  assign top_m1 = (top_q == '0) ? SW'(STACK_DEPTH - 1) : top_q - 1'b1;
  assign push_q = cmd_i.exec && (mode_q == 5'(tcx_pkg::OP_PUSH));
  assign pop_q  = cmd_i.wb2 && (mode_q == 5'(tcx_pkg::OP_POP));

  always_ff @(posedge clk_i) begin
    if (push_q) stk_mem[top_m1] <= x_q;
    if (cmd_i.exec) stk_rd_q <= stk_mem[top_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q  <= '0;
      fill_q <= '0;
    end else if (push_q) begin
      top_q  <= top_m1;
      if (fill_q != PW'(STACK_DEPTH)) fill_q <= fill_q + 1'b1;
    end else if (pop_q) begin
      top_q  <= (top_q == SW'(STACK_DEPTH - 1)) ? '0 : top_q + 1'b1;
      if (fill_q != '0) fill_q <= fill_q - 1'b1;
    end
  end

  // pop value is zero once the stack has run empty
  assign pop_val = (fill_q == '0) ? '0 : stk_rd_q;

  // result capture, reading the file after both writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      first_value_o  <= 32'(signed'(rf_q[ia_q]));
      second_value_o <= 32'(signed'(rf_q[ib_q]));
      flags_o        <= flags_q;
      skip_next_o    <= skip_q;
      divide_by_zero_o <= dz_q;
    end
  end

  `TCX_ASSERT(a_div_zero, clk_i, rst_ni, !(cmd_i.div_start && y_q == '0), "divide by zero started")
  `TCX_ASSERT(a_fill, clk_i, rst_ni, fill_q <= PW'(STACK_DEPTH), "stack fill out of range")
  `TCX_ASSERT_NEXT(a_div_cnt, clk_i, rst_ni, cmd_i.div_start, dcnt_q == CW'(W), "divider count not loaded")
endmodule
`default_nettype wire
